[src/jddp_pkg.sv]
package jddp_pkg;

    // field and register widths
    localparam int JOY_W      = 14;
    localparam int DZ_W       = 13;
    localparam int GAIN_W     = 12;
    localparam int DUTY_W     = 13;
    localparam int CNT_W      = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // mixing divides by 2**MIX_SHIFT
    localparam int MIX_SHIFT      = 13;
    localparam int JOY_CENTER_DEF = 8192;

    // reset values
    localparam logic [DZ_W-1:0]          DEADZONE_RST   = 13'd1000;
    localparam logic [GAIN_W-1:0]        TURN_GAIN_RST  = 12'd1500;
    localparam logic [GAIN_W-1:0]        DRIVE_GAIN_RST = 12'd2000;
    localparam logic [GAIN_W-1:0]        DUTY_LIMIT_RST = 12'd2000;
    localparam logic [CNT_W-1:0]         PERIOD_RST     = 12'd2000;
    localparam logic signed [DUTY_W-1:0] DUTY_RST       = 13'sd150;

    // input operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_JOY  = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADZONE   = 3'd0,
        CFG_TURN_GAIN  = 3'd1,
        CFG_DRIVE_GAIN = 3'd2,
        CFG_DUTY_LIMIT = 3'd3,
        CFG_PERIOD     = 3'd4
    } t_cfg_index;

    // settings used by the joystick mixer
    typedef struct packed {
        logic [DZ_W-1:0]   deadzone;
        logic [GAIN_W-1:0] turn_gain;
        logic [GAIN_W-1:0] drive_gain;
        logic [GAIN_W-1:0] duty_limit;
    } t_mix_cfg;

endpackage

[src/jddp_mix.sv]
module jddp_mix
    import jddp_pkg::*;
#(
    parameter int JOY_CENTER = JOY_CENTER_DEF
) (
    input  t_mix_cfg                  i_cfg,
    input  logic [JOY_W-1:0]          i_joy_x,
    input  logic [JOY_W-1:0]          i_joy_y,
    output logic signed [DUTY_W-1:0]  o_left_duty,
    output logic signed [DUTY_W-1:0]  o_right_duty
);

    // offset width covers both the center and the full joystick range
    localparam int CTR_W = ($clog2(JOY_CENTER + 1) > JOY_W) ? $clog2(JOY_CENTER + 1) : JOY_W;
    localparam int DW    = CTR_W + 1;
    localparam int PW    = DW + GAIN_W + 1;
    localparam int TW    = PW - MIX_SHIFT;
    localparam int SW    = TW + 2;
    localparam logic signed [DW-1:0] CENTER = DW'(JOY_CENTER);
    localparam logic signed [PW-1:0] ROUND  = PW'((1 << MIX_SHIFT) - 1);

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] dz;
    logic                 act_x;
    logic                 act_y;
    logic signed [PW-1:0] prod_x;
    logic signed [PW-1:0] prod_y;
    logic signed [PW-1:0] bias_x;
    logic signed [PW-1:0] bias_y;
    logic signed [PW-1:0] quo_x;
    logic signed [PW-1:0] quo_y;
    logic signed [TW-1:0] term_x;
    logic signed [TW-1:0] term_y;
    logic signed [SW-1:0] add_x;
    logic signed [SW-1:0] add_y;
    logic signed [SW-1:0] sum_l;
    logic signed [SW-1:0] sum_r;
    logic signed [SW-1:0] lim;

    // offsets from center and deadzone test
    always_comb begin
        dx    = CENTER - $signed({(DW - JOY_W)'(0), i_joy_x});
        dy    = CENTER - $signed({(DW - JOY_W)'(0), i_joy_y});
        dz    = $signed({(DW - DZ_W)'(0), i_cfg.deadzone});
        act_x = (dx > dz) || (dx < -dz);
        act_y = (dy > dz) || (dy < -dz);
    end

    // scaled terms, division truncates toward zero
    always_comb begin
        prod_x = PW'(dx) * $signed({(PW - GAIN_W)'(0), i_cfg.turn_gain});
        prod_y = PW'(dy) * $signed({(PW - GAIN_W)'(0), i_cfg.drive_gain});
        bias_x = prod_x[PW-1] ? ROUND : '0;
        bias_y = prod_y[PW-1] ? ROUND : '0;
        quo_x  = (prod_x + bias_x) >>> MIX_SHIFT;
        quo_y  = (prod_y + bias_y) >>> MIX_SHIFT;
        term_x = TW'(quo_x);
        term_y = TW'(quo_y);
    end

    // mix and clamp
    always_comb begin
        add_x = act_x ? SW'(term_x) : '0;
        add_y = act_y ? SW'(term_y) : '0;
        sum_l = SW'(1) + add_x + add_y;
        sum_r = SW'(1) - add_x + add_y;
        lim   = $signed({(SW - GAIN_W)'(0), i_cfg.duty_limit});

        if (sum_l > lim) begin
            o_left_duty = DUTY_W'(lim);
        end else if (sum_l < -lim) begin
            o_left_duty = DUTY_W'(-lim);
        end else begin
            o_left_duty = DUTY_W'(sum_l);
        end

        if (sum_r > lim) begin
            o_right_duty = DUTY_W'(lim);
        end else if (sum_r < -lim) begin
            o_right_duty = DUTY_W'(-lim);
        end else begin
            o_right_duty = DUTY_W'(sum_r);
        end
    end

endmodule

[src/joystick_differential_drive_pwm_core.sv]
// Two-motor sign-magnitude PWM with joystick mixing.
// Input channel (i_in_valid / o_in_ready) carries one transaction per item:
// i_op selects a timer tick or a joystick sample (i_joy_x, i_joy_y).
// Output channel (o_out_valid / i_out_ready) returns exactly one transaction
// per input item: drive levels, direction bits and the current signed duties.
// The path is an input register, then the mixing / PWM logic into
// the output register. One item is taken every cycle while the output side
// keeps up; the pair of registers lets one further item be taken while a
// result is held for a stalled receiver. The loop is the state update, which
// completes in the same cycle the item leaves the input register, so a tick
// right after a joystick sample sees the new duties.
// Configuration (i_cfg_wr_en, i_cfg_index, i_cfg_data) is written with
// no handshake; indexes past the last register are ignored.
// Reset (synchronous, active low) empties both registers, clears the tick
// counter and levels, sets both duties to 150 and loads default settings.
// When i_out_ready is low the result holds and the input register fills,
// after which o_in_ready drops until the result is taken.
module joystick_differential_drive_pwm_core
    import jddp_pkg::*;
#(
    parameter int JOY_CENTER = JOY_CENTER_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic                     i_op,
    input  logic [JOY_W-1:0]         i_joy_x,
    input  logic [JOY_W-1:0]         i_joy_y,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_left_drive,
    output logic                     o_left_dir,
    output logic                     o_right_drive,
    output logic                     o_right_dir,
    output logic signed [DUTY_W-1:0] o_left_duty_now,
    output logic signed [DUTY_W-1:0] o_right_duty_now
);

    // configuration registers
    t_mix_cfg          r_mix_cfg;
    logic [CNT_W-1:0]  r_period;

    // input register
    logic              r_in_valid;
    logic              r_in_op;
    logic [JOY_W-1:0]  r_in_joy_x;
    logic [JOY_W-1:0]  r_in_joy_y;

    // block state
    logic [CNT_W-1:0]         r_tick_count;
    logic signed [DUTY_W-1:0] r_left_duty;
    logic signed [DUTY_W-1:0] r_right_duty;
    logic                     r_left_level;
    logic                     r_right_level;

    // output register
    logic                     r_out_valid;
    logic                     r_out_left_drive;
    logic                     r_out_right_drive;
    logic signed [DUTY_W-1:0] r_out_left_duty;
    logic signed [DUTY_W-1:0] r_out_right_duty;

    logic                     advance;
    logic signed [DUTY_W-1:0] mix_left;
    logic signed [DUTY_W-1:0] mix_right;
    logic                     ldir;
    logic                     rdir;
    logic [CNT_W-1:0]         lmag;
    logic [CNT_W-1:0]         rmag;
    logic [CNT_W-1:0]         cnt_inc;

    logic [CNT_W-1:0]         n_tick_count;
    logic signed [DUTY_W-1:0] n_left_duty;
    logic signed [DUTY_W-1:0] n_right_duty;
    logic                     n_left_level;
    logic                     n_right_level;

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix_cfg.deadzone   <= DEADZONE_RST;
            r_mix_cfg.turn_gain  <= TURN_GAIN_RST;
            r_mix_cfg.drive_gain <= DRIVE_GAIN_RST;
            r_mix_cfg.duty_limit <= DUTY_LIMIT_RST;
            r_period             <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEADZONE:   r_mix_cfg.deadzone   <= DZ_W'(i_cfg_data);
                CFG_TURN_GAIN:  r_mix_cfg.turn_gain  <= GAIN_W'(i_cfg_data);
                CFG_DRIVE_GAIN: r_mix_cfg.drive_gain <= GAIN_W'(i_cfg_data);
                CFG_DUTY_LIMIT: r_mix_cfg.duty_limit <= GAIN_W'(i_cfg_data);
                CFG_PERIOD:     r_period             <= CNT_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_op    <= i_op;
            r_in_joy_x <= i_joy_x;
            r_in_joy_y <= i_joy_y;
        end
    end

    // joystick mixing
    jddp_mix #(
        .JOY_CENTER (JOY_CENTER)
    ) u_mix (
        .i_cfg        (r_mix_cfg),
        .i_joy_x      (r_in_joy_x),
        .i_joy_y      (r_in_joy_y),
        .o_left_duty  (mix_left),
        .o_right_duty (mix_right)
    );

    // next state for a tick or a joystick sample
    always_comb begin
        ldir    = r_left_duty[DUTY_W-1];
        rdir    = r_right_duty[DUTY_W-1];
        lmag    = ldir ? CNT_W'(-r_left_duty) : CNT_W'(r_left_duty);
        rmag    = rdir ? CNT_W'(-r_right_duty) : CNT_W'(r_right_duty);
        cnt_inc = r_tick_count + CNT_W'(1);

        n_tick_count  = r_tick_count;
        n_left_duty   = r_left_duty;
        n_right_duty  = r_right_duty;
        n_left_level  = r_left_level;
        n_right_level = r_right_level;

        if (r_in_op == OP_JOY) begin
            n_left_duty  = mix_left;
            n_right_duty = mix_right;
        end else begin
            n_tick_count = cnt_inc;
            if (cnt_inc == lmag) begin
                n_left_level = ldir;
            end
            if (cnt_inc == rmag) begin
                n_right_level = rdir;
            end
            // period end wins over the duty match
            if (cnt_inc >= r_period) begin
                n_tick_count  = '0;
                n_left_level  = !ldir;
                n_right_level = !rdir;
            end
        end
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_left_duty   <= DUTY_RST;
            r_right_duty  <= DUTY_RST;
            r_left_level  <= 1'b0;
            r_right_level <= 1'b0;
        end else if (advance) begin
            r_tick_count  <= n_tick_count;
            r_left_duty   <= n_left_duty;
            r_right_duty  <= n_right_duty;
            r_left_level  <= n_left_level;
            r_right_level <= n_right_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_left_drive  <= n_left_level;
            r_out_right_drive <= n_right_level;
            r_out_left_duty   <= n_left_duty;
            r_out_right_duty  <= n_right_duty;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_left_drive     = r_out_left_drive;
    assign o_right_drive    = r_out_right_drive;
    assign o_left_dir       = r_out_left_duty[DUTY_W-1];
    assign o_right_dir      = r_out_right_duty[DUTY_W-1];
    assign o_left_duty_now  = r_out_left_duty;
    assign o_right_duty_now = r_out_right_duty;

endmodule

[src/jddp_checker.sv]
module jddp_checker
    import jddp_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_ready,
    input logic                     o_out_valid,
    input logic                     i_out_ready,
    input logic                     o_left_drive,
    input logic                     o_left_dir,
    input logic                     o_right_drive,
    input logic                     o_right_dir,
    input logic signed [DUTY_W-1:0] o_left_duty_now,
    input logic signed [DUTY_W-1:0] o_right_duty_now
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_left_duty_now)
            && $stable(o_right_duty_now) && $stable(o_left_drive)
            && $stable(o_right_drive))
        else $error("result changed while stalled");

    // direction bits follow the duty sign
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_dir == o_left_duty_now[DUTY_W-1])
            && (o_right_dir == o_right_duty_now[DUTY_W-1]))
        else $error("direction does not match duty sign");

    // clamped duties never reach the most negative code
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_left_duty_now != {1'b1, {(DUTY_W-1){1'b0}}})
            && (o_right_duty_now != {1'b1, {(DUTY_W-1){1'b0}}}))
        else $error("duty outside clamp range");

    // a new result follows an accepted transaction
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching input transaction");

endmodule

bind joystick_differential_drive_pwm_core jddp_checker u_jddp_checker (.*);

[tb/drive_status_checker.sv]
`timescale 1ns / 100ps

module drive_status_checker
    import jddp_pkg::*;
#(
    parameter int JOY_CENTER = JOY_CENTER_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration writes
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    input  logic                     i_in_ready,
    input  logic                     i_op,
    input  logic [JOY_W-1:0]         i_joy_x,
    input  logic [JOY_W-1:0]         i_joy_y,
    // output channel
    input  logic                     i_out_valid,
    input  logic                     i_out_ready,
    input  logic                     i_left_drive,
    input  logic                     i_left_dir,
    input  logic                     i_right_drive,
    input  logic                     i_right_dir,
    input  logic signed [DUTY_W-1:0] i_left_duty_now,
    input  logic signed [DUTY_W-1:0] i_right_duty_now,
    // status for the test top
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_checked
);

    typedef struct {
        logic left_drive;
        logic left_dir;
        logic right_drive;
        logic right_dir;
        int   left_duty;
        int   right_duty;
    } t_drive_status;

    // mixer and pwm settings as last written
    logic [DZ_W-1:0]   dz_cfg;
    logic [GAIN_W-1:0] turn_cfg;
    logic [GAIN_W-1:0] drive_cfg;
    logic [GAIN_W-1:0] limit_cfg;
    logic [CNT_W-1:0]  period_cfg;

    // motor state
    int   tick_cnt;
    int   left_duty;
    int   right_duty;
    logic left_lvl;
    logic right_lvl;

    t_drive_status status_q[$];
    int fails   = 0;
    int checked = 0;

    function automatic bit axis_outside(int v);
        return (v > JOY_CENTER + int'(dz_cfg)) || (v < JOY_CENTER - int'(dz_cfg));
    endfunction

    function automatic int clamp_to_limit(int d);
        if (d > int'(limit_cfg))
            return int'(limit_cfg);
        if (d < -int'(limit_cfg))
            return -int'(limit_cfg);
        return d;
    endfunction

    function automatic int duty_mag(int d);
        return (d < 0) ? -d : d;
    endfunction

    // advance the motor state by one transaction and return the status it shows
    task automatic step_drive(input logic op, input logic [JOY_W-1:0] x,
                              input logic [JOY_W-1:0] y, output t_drive_status st);
        int   mix_l;
        int   mix_r;
        int   term;
        logic ldir;
        logic rdir;
        if (op == OP_JOY) begin
            mix_l = 1;
            mix_r = 1;
            // steering axis pushes the motors apart
            if (axis_outside(int'(x))) begin
                term = ((JOY_CENTER - int'(x)) * int'(turn_cfg)) / (1 << MIX_SHIFT);
                mix_l += term;
                mix_r -= term;
            end
            // drive axis moves both the same way
            if (axis_outside(int'(y))) begin
                term = ((JOY_CENTER - int'(y)) * int'(drive_cfg)) / (1 << MIX_SHIFT);
                mix_l += term;
                mix_r += term;
            end
            left_duty  = clamp_to_limit(mix_l);
            right_duty = clamp_to_limit(mix_r);
        end else begin
            ldir = (left_duty < 0);
            rdir = (right_duty < 0);
            tick_cnt = (tick_cnt + 1) % (1 << CNT_W);
            // duty match sets the level to the direction bit
            if (tick_cnt == duty_mag(left_duty))
                left_lvl = ldir;
            if (tick_cnt == duty_mag(right_duty))
                right_lvl = rdir;
            // period end wins over the match
            if (tick_cnt >= int'(period_cfg)) begin
                tick_cnt  = 0;
                left_lvl  = ~ldir;
                right_lvl = ~rdir;
            end
        end
        st.left_drive  = left_lvl;
        st.left_dir    = (left_duty < 0);
        st.right_drive = right_lvl;
        st.right_dir   = (right_duty < 0);
        st.left_duty   = left_duty;
        st.right_duty  = right_duty;
    endtask

    task automatic check_field(input string name, input integer want, input integer got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endtask

    // watch both channels and the config port
    always @(posedge i_clk) begin
        t_drive_status want;
        if (!i_rst_n) begin
            dz_cfg     = DEADZONE_RST;
            turn_cfg   = TURN_GAIN_RST;
            drive_cfg  = DRIVE_GAIN_RST;
            limit_cfg  = DUTY_LIMIT_RST;
            period_cfg = PERIOD_RST;
            tick_cnt   = 0;
            left_duty  = int'(DUTY_RST);
            right_duty = int'(DUTY_RST);
            left_lvl   = 1'b0;
            right_lvl  = 1'b0;
            status_q.delete();
        end else begin
            // register writes, unused indexes fall through
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_DEADZONE:   dz_cfg     = i_cfg_data[DZ_W-1:0];
                    CFG_TURN_GAIN:  turn_cfg   = i_cfg_data[GAIN_W-1:0];
                    CFG_DRIVE_GAIN: drive_cfg  = i_cfg_data[GAIN_W-1:0];
                    CFG_DUTY_LIMIT: limit_cfg  = i_cfg_data[GAIN_W-1:0];
                    CFG_PERIOD:     period_cfg = i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
            // result transaction against the oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    $error("result transaction with no input transaction waiting");
                    fails++;
                end else begin
                    want = status_q.pop_front();
                    check_field("left_drive", integer'(want.left_drive),
                                integer'(i_left_drive));
                    check_field("left_dir", integer'(want.left_dir), integer'(i_left_dir));
                    check_field("right_drive", integer'(want.right_drive),
                                integer'(i_right_drive));
                    check_field("right_dir", integer'(want.right_dir),
                                integer'(i_right_dir));
                    check_field("left_duty_now", want.left_duty,
                                integer'(i_left_duty_now));
                    check_field("right_duty_now", want.right_duty,
                                integer'(i_right_duty_now));
                    checked++;
                end
            end
            // input transaction
            if (i_in_valid && i_in_ready) begin
                step_drive(i_op, i_joy_x, i_joy_y, want);
                status_q.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= status_q.size();
        o_checked    <= checked;
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
    import jddp_pkg::*;

    localparam int JOY_MAX       = 2**JOY_W - 1;
    localparam int CFG_IDX_LAST  = 2**CFG_IDX_W - 1;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 110;

    // block inputs
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_op     = OP_TICK;
    logic [JOY_W-1:0]      joy_x     = '0;
    logic [JOY_W-1:0]      joy_y     = '0;
    logic                  out_ready = 1'b0;

    // block outputs
    logic                     in_ready;
    logic                     out_valid;
    logic                     left_drive;
    logic                     left_dir;
    logic                     right_drive;
    logic                     right_dir;
    logic signed [DUTY_W-1:0] left_duty_now;
    logic signed [DUTY_W-1:0] right_duty_now;

    int fail_count;
    int pending;
    int checked;

    // idling control and bookkeeping
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    int rx_hold     = 0;
    int rx_roll;
    int cur_dz      = int'(DEADZONE_RST);
    int items_sent  = 0;
    int joy_sent    = 0;
    int cfg_changes = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    joystick_differential_drive_pwm_core #(
        .JOY_CENTER(JOY_CENTER_DEF)
    ) DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_op            (in_op),
        .i_joy_x         (joy_x),
        .i_joy_y         (joy_y),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_left_drive    (left_drive),
        .o_left_dir      (left_dir),
        .o_right_drive   (right_drive),
        .o_right_dir     (right_dir),
        .o_left_duty_now (left_duty_now),
        .o_right_duty_now(right_duty_now)
    );

    drive_status_checker #(
        .JOY_CENTER(JOY_CENTER_DEF)
    ) checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_op            (in_op),
        .i_joy_x         (joy_x),
        .i_joy_y         (joy_y),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_left_drive    (left_drive),
        .i_left_dir      (left_dir),
        .i_right_drive   (right_drive),
        .i_right_dir     (right_dir),
        .i_left_duty_now (left_duty_now),
        .i_right_duty_now(right_duty_now),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // receiver stalls, mostly short and now and then long
    always @(posedge clk) begin
        if (rx_calm) begin
            out_ready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold--;
            out_ready <= 1'b0;
        end else begin
            rx_roll = $urandom_range(99);
            if (rx_roll < 4)
                rx_hold = $urandom_range(40, 10);
            else if (rx_roll < 25)
                rx_hold = $urandom_range(3, 1);
            out_ready <= (rx_hold == 0);
        end
    end

    function automatic int pick_gap();
        int roll;
        if (tx_calm)
            return 0;
        roll = $urandom_range(99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // axis sample biased to the rails and the deadzone edges
    function automatic logic [JOY_W-1:0] pick_axis();
        int v;
        case ($urandom_range(9))
            0:       v = 0;
            1:       v = JOY_MAX;
            2:       v = JOY_CENTER_DEF + cur_dz;
            3:       v = JOY_CENTER_DEF + cur_dz + 1;
            4:       v = JOY_CENTER_DEF - cur_dz;
            5:       v = JOY_CENTER_DEF - cur_dz - 1;
            default: v = $urandom_range(JOY_MAX);
        endcase
        if (v < 0)
            v = 0;
        if (v > JOY_MAX)
            v = JOY_MAX;
        return v[JOY_W-1:0];
    endfunction

    // one input transaction after a random gap
    task automatic send_item(input logic op, input logic [JOY_W-1:0] x,
                             input logic [JOY_W-1:0] y);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        joy_x    <= x;
        joy_y    <= y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
        if (op == OP_JOY)
            joy_sent++;
    endtask

    task automatic send_random();
        send_item(($urandom_range(99) < 22) ? OP_JOY : OP_TICK, pick_axis(), pick_axis());
    endtask

    // stop sending and wait until every result is back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // new settings, written only once the block is idle
    task automatic set_config(input int dz, input int tg, input int dg, input int lim,
                              input int per, input bit poke_unused);
        drain();
        cfg_write(CFG_DEADZONE, CFG_DATA_W'(dz));
        cfg_write(CFG_TURN_GAIN, CFG_DATA_W'(tg));
        cfg_write(CFG_DRIVE_GAIN, CFG_DATA_W'(dg));
        cfg_write(CFG_DUTY_LIMIT, CFG_DATA_W'(lim));
        cfg_write(CFG_PERIOD, CFG_DATA_W'(per));
        // indexes past the last register must change nothing
        if (poke_unused)
            for (int k = int'(CFG_PERIOD) + 1; k <= CFG_IDX_LAST; k++)
                cfg_write(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        cfg_wr_en <= 1'b0;
        cur_dz = dz;
        cfg_changes++;
    endtask

    initial begin
        int per;
        int lim;
        int cap;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: rails, deadzone edges, center
        send_item(OP_JOY, '0, '0);
        send_item(OP_JOY, JOY_W'(JOY_MAX), JOY_W'(JOY_MAX));
        send_item(OP_JOY, '0, JOY_W'(JOY_MAX));
        send_item(OP_JOY, JOY_W'(JOY_MAX), '0);
        send_item(OP_JOY, JOY_W'(JOY_CENTER_DEF + cur_dz), JOY_W'(JOY_CENTER_DEF - cur_dz));
        send_item(OP_JOY, JOY_W'(JOY_CENTER_DEF + cur_dz + 1),
                  JOY_W'(JOY_CENTER_DEF - cur_dz - 1));
        send_item(OP_JOY, JOY_W'(JOY_CENTER_DEF), JOY_W'(JOY_CENTER_DEF));
        send_item(OP_TICK, '0, '0);
        send_item(OP_TICK, JOY_W'(JOY_MAX), JOY_W'(JOY_MAX));

        // zero duty: levels only move at the period
        set_config(int'(DEADZONE_RST), int'(TURN_GAIN_RST), int'(DRIVE_GAIN_RST), 0, 3, 1'b1);
        send_item(OP_JOY, '0, JOY_W'(JOY_MAX));
        repeat (4) send_item(OP_TICK, '0, '0);

        // negative and positive duties hit inside a short period
        set_config(0, 4095, 4095, 2, 3, 1'b0);
        send_item(OP_JOY, JOY_W'(JOY_MAX), JOY_W'(JOY_MAX));
        repeat (4) send_item(OP_TICK, '0, '0);

        // period zero clears on every tick
        set_config(0, 4095, 4095, 2, 0, 1'b0);
        repeat (3) send_item(OP_TICK, '0, '0);
        send_item(OP_JOY, '0, JOY_W'(JOY_MAX));
        send_item(OP_TICK, '0, '0);

        // random phases, the first two at the extremes
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: set_config(8191, 4095, 4095, 4095, 4095, 1'b0);
                1: set_config(0, 0, 0, 0, 1, 1'b0);
                default: begin
                    per = ($urandom_range(3) == 0) ? $urandom_range(4095, 1)
                                                   : $urandom_range(48, 1);
                    cap = (3 * per + 8 > 4095) ? 4095 : 3 * per + 8;
                    lim = $urandom_range((per + 4 > 4095) ? 4095 : per + 4);
                    set_config(($urandom_range(1) == 1) ? $urandom_range(1500)
                                                        : $urandom_range(8191),
                               $urandom_range(cap), $urandom_range(cap), lim, per, 1'b0);
                end
            endcase
            tx_calm = (ph % 4 == 3);
            rx_calm = (ph % 4 >= 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold the sender until the pipe is empty
                if (ph == 6 && n == PHASE_ITEMS / 2)
                    drain();
                send_random();
            end
        end

        drain();
        repeat (4) @(posedge clk);
        $display("sent %0d transactions (%0d joystick samples, %0d ticks) under %0d settings",
                 items_sent, joy_sent, items_sent - joy_sent, cfg_changes + 1);
        $display("compared %0d results, %0d mismatches", checked, fail_count);
        if (fail_count == 0)
            $display("joystick_differential_drive_pwm_core test passed");
        else
            $display("joystick_differential_drive_pwm_core test failed");
        $finish;
    end

    // watchdog
    initial begin
        #8000000;
        $display("joystick_differential_drive_pwm_core test failed");
        $finish;
    end

endmodule
